/* rtl/core/wmsc_pkg.sv */
`timescale 1ns / 1ps

package wmsc_pkg;

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_ID      = 6'b000010,
    PH_SIZE    = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_DONE    = 6'b010000,
    PH_HOLD    = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    CNT_DECODING = 3'b001,
    CNT_OK       = 3'b010,
    CNT_FAILED   = 3'b100
  } count_state_t;

  typedef enum logic [1:0] {
    VERDICT_NO_MATCH    = 2'd0,
    VERDICT_MATCHED     = 2'd1,
    VERDICT_PART_HEADER = 2'd2,
    VERDICT_PART_PAYLOAD = 2'd3
  } verdict_t;

  localparam logic REG_MAX_SECTION_ID = 1'b0;
  localparam logic REG_MAX_VERSION    = 1'b1;

  localparam logic [3:0][7:0] MAGIC = {8'h6D, 8'h73, 8'h61, 8'h00};

  localparam logic [7:0]  RESET_MAX_SECTION_ID = 8'd12;
  localparam logic [31:0] RESET_MAX_VERSION    = 32'd1;

  localparam logic [7:0] ID_TYPE     = 8'd1;
  localparam logic [7:0] ID_IMPORT   = 8'd2;
  localparam logic [7:0] ID_FUNCTION = 8'd3;
  localparam logic [7:0] ID_EXPORT   = 8'd7;

  localparam logic [2:0] LEB_MAX_BYTES = 3'd5;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  function automatic logic [31:0] leb_add(input logic [31:0] acc, input logic [2:0] idx,
                                          input logic [7:0] b);
    logic [31:0] part;
    logic [4:0]  sh;
    logic [31:0] res;
    part = {25'b0, b[6:0]};
    sh   = 5'(idx[1:0]) * 5'd7;
    if (idx < 3'd4) begin
      res = acc | (part << sh);
    end else if (b[6:4] != 3'b000) begin
      res = SAT32;
    end else begin
      res = acc | (part << 28);
    end
    return res;
  endfunction

endpackage

/* rtl/core/wmsc_if.sv */
`timescale 1ns / 1ps

interface wmsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wmsc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [31:0] match_length;
  logic [31:0] module_version;
  logic [31:0] section_total;
  logic [31:0] type_total;
  logic [31:0] import_total;
  logic [31:0] function_total;
  logic [31:0] export_total;

  modport source (output valid, output verdict, output match_length, output module_version,
                  output section_total, output type_total, output import_total,
                  output function_total, output export_total, input ready);
  modport sink (input valid, input verdict, input match_length, input module_version,
                input section_total, input type_total, input import_total,
                input function_total, input export_total, output ready);
endinterface

/* rtl/core/wasm_module_stream_checker.sv */
`timescale 1ns / 1ps
// a verdict is registered at the edge that takes its byte and is on the output right after that edge
// throughput: one byte per cycle, set by the registered parse state update, except that the
// input stalls, which it does only while a verdict is held and the result side is not ready
// rst_n (synchronous, active low) clears the stream state and the output valid flag
// and restores max_section_id to 12 and max_version to 1

module wasm_module_stream_checker (
  input  logic              clk,
  input  logic              rst_n,
  wmsc_in_if.sink           in_chan,
  wmsc_out_if.source        out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // configuration
  logic [7:0]  max_section_id_r;
  logic [31:0] max_version_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_section_id_r <= wmsc_pkg::RESET_MAX_SECTION_ID;
      max_version_r    <= wmsc_pkg::RESET_MAX_VERSION;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == wmsc_pkg::REG_MAX_SECTION_ID) begin
        max_section_id_r <= cfg_pwdata[7:0];
      end else begin
        max_version_r <= cfg_pwdata;
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == wmsc_pkg::REG_MAX_VERSION) begin
      cfg_prdata = max_version_r;
    end else begin
      cfg_prdata = {24'b0, max_section_id_r};
    end
  end

  // stream state
  wmsc_pkg::phase_t       phase_r, phase_nxt;
  wmsc_pkg::count_state_t cnt_state_r, cnt_state_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic [31:0] version_r, version_nxt;
  logic [31:0] bytes_seen_r, bytes_seen_nxt;
  logic [7:0]  prev_id_r, prev_id_nxt;
  logic [7:0]  cur_id_r, cur_id_nxt;
  logic        any_seen_r, any_seen_nxt;
  logic [31:0] size_acc_r, size_acc_nxt;
  logic [2:0]  size_idx_r, size_idx_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [31:0] cnt_acc_r, cnt_acc_nxt;
  logic [2:0]  cnt_idx_r, cnt_idx_nxt;
  logic [31:0] sect_cnt_r, sect_cnt_nxt;
  logic [31:0] type_cnt_r, type_cnt_nxt;
  logic [31:0] import_cnt_r, import_cnt_nxt;
  logic [31:0] func_cnt_r, func_cnt_nxt;
  logic [31:0] export_cnt_r, export_cnt_nxt;

  logic        in_fire;
  logic [7:0]  b;
  logic        last;
  logic        emit;
  logic        finish;
  wmsc_pkg::verdict_t verdict;
  logic [31:0] len;

  // output register
  logic        out_valid_r;
  logic [1:0]  o_verdict_r;
  logic [31:0] o_len_r, o_version_r, o_sect_r, o_type_r, o_import_r, o_func_r, o_export_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign b             = in_chan.data_byte;
  assign last          = in_chan.last_byte;

  always_comb begin
    phase_nxt      = phase_r;
    cnt_state_nxt  = cnt_state_r;
    hdr_idx_nxt    = hdr_idx_r;
    version_nxt    = version_r;
    bytes_seen_nxt = bytes_seen_r;
    prev_id_nxt    = prev_id_r;
    cur_id_nxt     = cur_id_r;
    any_seen_nxt   = any_seen_r;
    size_acc_nxt   = size_acc_r;
    size_idx_nxt   = size_idx_r;
    remain_nxt     = remain_r;
    cnt_acc_nxt    = cnt_acc_r;
    cnt_idx_nxt    = cnt_idx_r;
    sect_cnt_nxt   = sect_cnt_r;
    type_cnt_nxt   = type_cnt_r;
    import_cnt_nxt = import_cnt_r;
    func_cnt_nxt   = func_cnt_r;
    export_cnt_nxt = export_cnt_r;
    emit           = 1'b0;
    finish         = 1'b0;
    verdict        = wmsc_pkg::VERDICT_NO_MATCH;
    len            = 32'd0;

    if (in_fire && phase_r != wmsc_pkg::PH_DONE) begin
      if (bytes_seen_r != wmsc_pkg::SAT32) begin
        bytes_seen_nxt = bytes_seen_r + 32'd1;
      end

      unique case (phase_r)
        wmsc_pkg::PH_HEADER: begin
          if (!hdr_idx_r[2]) begin
            if (b != wmsc_pkg::MAGIC[hdr_idx_r[1:0]]) begin
              emit = 1'b1;
            end
          end else begin
            version_nxt = version_r | ({24'b0, b} << {hdr_idx_r[1:0], 3'b000});
            if (hdr_idx_r == 3'd7) begin
              if (version_nxt == 32'd0 || version_nxt > max_version_r) begin
                emit = 1'b1;
              end else begin
                phase_nxt = wmsc_pkg::PH_ID;
              end
            end
          end
          hdr_idx_nxt = hdr_idx_r + 3'd1;
          if (last) begin
            emit = 1'b1;
          end
        end
        wmsc_pkg::PH_ID: begin
          if (b > max_section_id_r || (b != 8'd0 && b < prev_id_r)) begin
            emit    = 1'b1;
            verdict = any_seen_r ? wmsc_pkg::VERDICT_MATCHED : wmsc_pkg::VERDICT_NO_MATCH;
            len     = bytes_seen_r;
          end else begin
            if (b != 8'd0) begin
              prev_id_nxt = b;
            end
            cur_id_nxt   = b;
            size_acc_nxt = 32'd0;
            size_idx_nxt = 3'd0;
            phase_nxt    = wmsc_pkg::PH_SIZE;
            if (last) begin
              emit    = 1'b1;
              verdict = wmsc_pkg::VERDICT_PART_HEADER;
              len     = bytes_seen_nxt;
            end
          end
        end
        wmsc_pkg::PH_SIZE: begin
          size_acc_nxt = wmsc_pkg::leb_add(size_acc_r, size_idx_r, b);
          size_idx_nxt = size_idx_r + 3'd1;
          if (b[7]) begin
            if (size_idx_nxt >= wmsc_pkg::LEB_MAX_BYTES) begin
              phase_nxt = wmsc_pkg::PH_HOLD;
            end
            if (last) begin
              emit    = 1'b1;
              verdict = wmsc_pkg::VERDICT_PART_HEADER;
              len     = bytes_seen_nxt;
            end
          end else begin
            remain_nxt    = size_acc_nxt;
            cnt_acc_nxt   = 32'd0;
            cnt_idx_nxt   = 3'd0;
            cnt_state_nxt = wmsc_pkg::CNT_DECODING;
            if (size_acc_nxt == 32'd0) begin
              cnt_state_nxt = wmsc_pkg::CNT_FAILED;
              finish        = 1'b1;
              phase_nxt     = wmsc_pkg::PH_ID;
              if (last) begin
                emit    = 1'b1;
                verdict = wmsc_pkg::VERDICT_MATCHED;
                len     = bytes_seen_nxt;
              end
            end else begin
              phase_nxt = wmsc_pkg::PH_PAYLOAD;
              if (last) begin
                emit    = 1'b1;
                verdict = wmsc_pkg::VERDICT_PART_PAYLOAD;
                len     = bytes_seen_nxt;
              end
            end
          end
        end
        wmsc_pkg::PH_PAYLOAD: begin
          if (cnt_state_r == wmsc_pkg::CNT_DECODING) begin
            cnt_acc_nxt = wmsc_pkg::leb_add(cnt_acc_r, cnt_idx_r, b);
            cnt_idx_nxt = cnt_idx_r + 3'd1;
            if (!b[7]) begin
              cnt_state_nxt = wmsc_pkg::CNT_OK;
            end else if (cnt_idx_nxt >= wmsc_pkg::LEB_MAX_BYTES) begin
              cnt_state_nxt = wmsc_pkg::CNT_FAILED;
            end
          end
          remain_nxt = remain_r - 32'd1;
          if (remain_nxt == 32'd0) begin
            if (cnt_state_nxt == wmsc_pkg::CNT_DECODING) begin
              cnt_state_nxt = wmsc_pkg::CNT_FAILED;
            end
            finish    = 1'b1;
            phase_nxt = wmsc_pkg::PH_ID;
            if (last) begin
              emit    = 1'b1;
              verdict = wmsc_pkg::VERDICT_MATCHED;
              len     = bytes_seen_nxt;
            end
          end else if (last) begin
            emit    = 1'b1;
            verdict = wmsc_pkg::VERDICT_PART_PAYLOAD;
            len     = bytes_seen_nxt;
          end
        end
        default: begin
          if (last) begin
            emit    = 1'b1;
            verdict = wmsc_pkg::VERDICT_PART_HEADER;
            len     = bytes_seen_nxt;
          end
        end
      endcase

      // section complete
      if (finish) begin
        if (sect_cnt_r != wmsc_pkg::SAT32) begin
          sect_cnt_nxt = sect_cnt_r + 32'd1;
        end
        any_seen_nxt = 1'b1;
        if (cnt_state_nxt == wmsc_pkg::CNT_OK) begin
          if (cur_id_r == wmsc_pkg::ID_TYPE) begin
            type_cnt_nxt = cnt_acc_nxt;
          end
          if (cur_id_r == wmsc_pkg::ID_IMPORT) begin
            import_cnt_nxt = cnt_acc_nxt;
          end
          if (cur_id_r == wmsc_pkg::ID_FUNCTION) begin
            func_cnt_nxt = cnt_acc_nxt;
          end
          if (cur_id_r == wmsc_pkg::ID_EXPORT) begin
            export_cnt_nxt = cnt_acc_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && last)) begin
      phase_r      <= wmsc_pkg::PH_HEADER;
      cnt_state_r  <= wmsc_pkg::CNT_DECODING;
      hdr_idx_r    <= 3'd0;
      version_r    <= 32'd0;
      bytes_seen_r <= 32'd0;
      prev_id_r    <= 8'd0;
      cur_id_r     <= 8'd0;
      any_seen_r   <= 1'b0;
      size_acc_r   <= 32'd0;
      size_idx_r   <= 3'd0;
      remain_r     <= 32'd0;
      cnt_acc_r    <= 32'd0;
      cnt_idx_r    <= 3'd0;
      sect_cnt_r   <= 32'd0;
      type_cnt_r   <= 32'd0;
      import_cnt_r <= 32'd0;
      func_cnt_r   <= 32'd0;
      export_cnt_r <= 32'd0;
    end else begin
      phase_r      <= emit ? wmsc_pkg::PH_DONE : phase_nxt;
      cnt_state_r  <= cnt_state_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      version_r    <= version_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      prev_id_r    <= prev_id_nxt;
      cur_id_r     <= cur_id_nxt;
      any_seen_r   <= any_seen_nxt;
      size_acc_r   <= size_acc_nxt;
      size_idx_r   <= size_idx_nxt;
      remain_r     <= remain_nxt;
      cnt_acc_r    <= cnt_acc_nxt;
      cnt_idx_r    <= cnt_idx_nxt;
      sect_cnt_r   <= sect_cnt_nxt;
      type_cnt_r   <= type_cnt_nxt;
      import_cnt_r <= import_cnt_nxt;
      func_cnt_r   <= func_cnt_nxt;
      export_cnt_r <= export_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      o_verdict_r <= verdict;
      if (verdict == wmsc_pkg::VERDICT_NO_MATCH) begin
        o_len_r     <= 32'd0;
        o_version_r <= 32'd0;
        o_sect_r    <= 32'd0;
        o_type_r    <= 32'd0;
        o_import_r  <= 32'd0;
        o_func_r    <= 32'd0;
        o_export_r  <= 32'd0;
      end else begin
        o_len_r     <= len;
        o_version_r <= version_nxt;
        o_sect_r    <= sect_cnt_nxt;
        o_type_r    <= type_cnt_nxt;
        o_import_r  <= import_cnt_nxt;
        o_func_r    <= func_cnt_nxt;
        o_export_r  <= export_cnt_nxt;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.verdict        = o_verdict_r;
  assign out_chan.match_length   = o_len_r;
  assign out_chan.module_version = o_version_r;
  assign out_chan.section_total  = o_sect_r;
  assign out_chan.type_total     = o_type_r;
  assign out_chan.import_total   = o_import_r;
  assign out_chan.function_total = o_func_r;
  assign out_chan.export_total   = o_export_r;

  // checks
  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_verdict_r == wmsc_pkg::VERDICT_NO_MATCH
      |-> o_len_r == 32'd0 && o_sect_r == 32'd0 && o_version_r == 32'd0)
    else $error("no-match verdict carries nonzero fields");

  a_match_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_verdict_r == wmsc_pkg::VERDICT_MATCHED |-> o_len_r >= 32'd10)
    else $error("matched verdict shorter than header plus one section");

  a_verdict_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && emit && !last |=> phase_r == wmsc_pkg::PH_DONE)
    else $error("stream not closed after its verdict");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last |=> phase_r == wmsc_pkg::PH_HEADER && bytes_seen_r == 32'd0
      && sect_cnt_r == 32'd0)
    else $error("stream state not cleared after last byte");

  a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == wmsc_pkg::PH_DONE |-> !emit)
    else $error("second verdict in one stream");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    wmsc_pkg::verdict_t verdict;
    logic [31:0] match_len;
    logic [31:0] mod_ver;
    logic [31:0] sec_total;
    logic [31:0] type_cnt;
    logic [31:0] import_cnt;
    logic [31:0] func_cnt;
    logic [31:0] export_cnt;
  } verdict_rec_t;

  typedef struct {
    string        hexbytes;
    bit           typed;
    verdict_rec_t want;
  } stim_row_t;

  localparam string HDR = "00 61 73 6d 01 00 00 00";
  localparam verdict_rec_t NO_MATCH_REC = '0;
  localparam int PHASES = 5;
  localparam int BYTES_PER_PHASE = 130;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  wmsc_in_if  in_if ();
  wmsc_out_if out_if ();

  wasm_module_stream_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  verdict_rec_t pending_verdicts[$];
  logic [7:0]   stream_buf[$];
  stim_row_t    stim_table[20];
  int           err_count = 0;
  int           accepted_bytes = 0;
  int           results_taken = 0;
  int           src_burst = 0;
  int           sink_burst = 0;

  // module walker state
  logic [7:0]             cfg_max_id;
  logic [31:0]            cfg_max_ver;
  wmsc_pkg::phase_t       ph;
  logic [2:0]             hdr_idx;
  logic [31:0]            ver_word;
  logic [31:0]            nbytes;
  logic [7:0]             prev_std;
  logic [7:0]             cur_id;
  bit                     seen_any;
  logic [31:0]            size_acc;
  logic [2:0]             size_idx;
  logic [31:0]            remaining;
  logic [31:0]            cnt_acc;
  logic [2:0]             cnt_idx;
  wmsc_pkg::count_state_t cnt_st;
  logic [31:0]            nsections;
  logic [31:0]            kinds[4];

  function void clear_stream();
    ph        = wmsc_pkg::PH_HEADER;
    hdr_idx   = '0;
    ver_word  = '0;
    nbytes    = '0;
    prev_std  = '0;
    cur_id    = '0;
    seen_any  = 1'b0;
    size_acc  = '0;
    size_idx  = '0;
    remaining = '0;
    cnt_acc   = '0;
    cnt_idx   = '0;
    cnt_st    = wmsc_pkg::CNT_DECODING;
    nsections = '0;
    foreach (kinds[k]) kinds[k] = '0;
  endfunction

  function void put_byte(input logic [7:0] v);
    stream_buf.insert(stream_buf.size(), v);
  endfunction

  function automatic logic [31:0] leb_merge(input logic [31:0] acc, input logic [2:0] idx,
                                            input logic [7:0] b);
    if (idx < 3'd4) return acc | ({25'b0, b[6:0]} << (7 * idx));
    if (b[6:4] != 3'b000) return wmsc_pkg::SAT32;
    return acc | {b[3:0], 28'b0};
  endfunction

  function void close_section();
    if (nsections != wmsc_pkg::SAT32) nsections++;
    seen_any = 1'b1;
    if (cnt_st == wmsc_pkg::CNT_OK) begin
      case (cur_id)
        wmsc_pkg::ID_TYPE:     kinds[0] = cnt_acc;
        wmsc_pkg::ID_IMPORT:   kinds[1] = cnt_acc;
        wmsc_pkg::ID_FUNCTION: kinds[2] = cnt_acc;
        wmsc_pkg::ID_EXPORT:   kinds[3] = cnt_acc;
        default: ;
      endcase
    end
  endfunction

  task automatic walk_module_byte(input logic [7:0] b, input bit l, output bit got,
                                  output verdict_rec_t r);
    int          v;
    logic [31:0] pre_len;
    logic [31:0] len;
    v   = -1;
    len = '0;
    got = 1'b0;
    r   = '0;
    if (ph == wmsc_pkg::PH_DONE) begin
      if (l) clear_stream();
      return;
    end
    pre_len = nbytes;
    if (nbytes != wmsc_pkg::SAT32) nbytes++;
    case (ph)
      wmsc_pkg::PH_HEADER: begin
        if (hdr_idx < 3'd4) begin
          if (b != wmsc_pkg::MAGIC[hdr_idx[1:0]]) v = 0;
        end else begin
          ver_word |= 32'(b) << (8 * (hdr_idx - 3'd4));
          if (hdr_idx == 3'd7) begin
            if (ver_word == 0 || ver_word > cfg_max_ver) v = 0;
            else ph = wmsc_pkg::PH_ID;
          end
        end
        hdr_idx = hdr_idx + 3'd1;
        if (v < 0 && l) v = 0;
      end
      wmsc_pkg::PH_ID: begin
        if (b > cfg_max_id || (b != 0 && b < prev_std)) begin
          v   = seen_any ? 1 : 0;
          len = pre_len;
        end else begin
          if (b != 0) prev_std = b;
          cur_id   = b;
          size_acc = '0;
          size_idx = '0;
          ph       = wmsc_pkg::PH_SIZE;
          if (l) begin
            v   = 2;
            len = nbytes;
          end
        end
      end
      wmsc_pkg::PH_SIZE: begin
        size_acc = leb_merge(size_acc, size_idx, b);
        size_idx = size_idx + 3'd1;
        if (b[7]) begin
          if (size_idx >= wmsc_pkg::LEB_MAX_BYTES) ph = wmsc_pkg::PH_HOLD;
          if (l) begin
            v   = 2;
            len = nbytes;
          end
        end else begin
          remaining = size_acc;
          cnt_acc   = '0;
          cnt_idx   = '0;
          cnt_st    = wmsc_pkg::CNT_DECODING;
          if (remaining == 0) begin
            cnt_st = wmsc_pkg::CNT_FAILED;
            close_section();
            ph = wmsc_pkg::PH_ID;
            if (l) begin
              v   = 1;
              len = nbytes;
            end
          end else begin
            ph = wmsc_pkg::PH_PAYLOAD;
            if (l) begin
              v   = 3;
              len = nbytes;
            end
          end
        end
      end
      wmsc_pkg::PH_PAYLOAD: begin
        if (cnt_st == wmsc_pkg::CNT_DECODING) begin
          cnt_acc = leb_merge(cnt_acc, cnt_idx, b);
          cnt_idx = cnt_idx + 3'd1;
          if (!b[7]) cnt_st = wmsc_pkg::CNT_OK;
          else if (cnt_idx >= wmsc_pkg::LEB_MAX_BYTES) cnt_st = wmsc_pkg::CNT_FAILED;
        end
        remaining--;
        if (remaining == 0) begin
          if (cnt_st == wmsc_pkg::CNT_DECODING) cnt_st = wmsc_pkg::CNT_FAILED;
          close_section();
          ph = wmsc_pkg::PH_ID;
          if (l) begin
            v   = 1;
            len = nbytes;
          end
        end else if (l) begin
          v   = 3;
          len = nbytes;
        end
      end
      default: begin
        if (l) begin
          v   = 2;
          len = nbytes;
        end
      end
    endcase
    if (v < 0) begin
      if (l) clear_stream();
      return;
    end
    got = 1'b1;
    r.verdict = wmsc_pkg::verdict_t'(2'(v));
    if (v != 0) begin
      r.match_len  = len;
      r.mod_ver    = ver_word;
      r.sec_total  = nsections;
      r.type_cnt   = kinds[0];
      r.import_cnt = kinds[1];
      r.func_cnt   = kinds[2];
      r.export_cnt = kinds[3];
    end
    if (l) clear_stream();
    else ph = wmsc_pkg::PH_DONE;
  endtask

  function automatic int draw_gap(ref int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(24, 0) == 0) burst_left = $urandom_range(60, 20);
    return $urandom_range(19, 0);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit l);
    int gap;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= l;
    do @(posedge clk); while (!in_if.ready);
    accepted_bytes++;
  endtask

  task automatic send_stream(input logic [7:0] q[$], input bit typed, input verdict_rec_t want);
    bit           got;
    bit           l;
    verdict_rec_t r;
    foreach (q[i]) begin
      l = (i == q.size() - 1);
      send_byte(q[i], l);
      walk_module_byte(q[i], l, got, r);
      if (got) pending_verdicts.insert(pending_verdicts.size(), typed ? want : r);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] rb_want;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    rb_want = (idx == wmsc_pkg::REG_MAX_SECTION_ID) ? {24'b0, value[7:0]} : value;
    if (cfg_prdata !== rb_want) begin
      $display("%0t cfg readback mismatch: expected %h, got %h", $time, rb_want, cfg_prdata);
      err_count++;
    end
    if (idx == wmsc_pkg::REG_MAX_SECTION_ID) cfg_max_id = value[7:0];
    else cfg_max_ver = value;
  endtask

  task automatic build_random_stream();
    logic [31:0] vers;
    logic [7:0]  b;
    int          nsec;
    int          prev;
    int          hi;
    int          id;
    int          sz;
    int          n;
    int          cl;
    int          mode;
    int          cut;
    stream_buf.delete();
    if ($urandom_range(9, 0) == 0) begin
      n = $urandom_range(12, 1);
      if ($urandom_range(1, 0) == 1) for (int i = 0; i < 4; i++) put_byte(wmsc_pkg::MAGIC[i]);
      repeat (n) put_byte(8'($urandom));
      return;
    end
    for (int i = 0; i < 4; i++) put_byte(wmsc_pkg::MAGIC[i]);
    case ($urandom_range(9, 0))
      0: vers = '0;
      1: vers = (cfg_max_ver == wmsc_pkg::SAT32) ? $urandom : cfg_max_ver + 1;
      default: vers = $urandom_range(cfg_max_ver, 1);
    endcase
    for (int i = 0; i < 4; i++) put_byte(vers[8*i +: 8]);
    if ($urandom_range(19, 0) == 0) begin
      n = $urandom_range(7, 0);
      stream_buf[n] = stream_buf[n] ^ 8'($urandom_range(255, 1));
    end
    nsec = $urandom_range(5, 0);
    prev = 0;
    repeat (nsec) begin
      hi = (cfg_max_id > 12 && $urandom_range(7, 0) != 0) ? 12 : int'(cfg_max_id);
      id = $urandom_range(hi, 0);
      if (id != 0 && id < prev) id = prev;
      if (id != 0) prev = id;
      put_byte(8'(id));
      sz = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 0);
      n  = 1 + (($urandom_range(5, 0) == 0) ? $urandom_range(3, 0) : 0);
      for (int i = 0; i < n; i++) begin
        b = 8'((sz >> (7 * i)) & 32'h7f);
        if (i < n - 1) b[7] = 1'b1;
        put_byte(b);
      end
      cl = $urandom_range(6, 1);
      for (int i = 0; i < sz; i++) begin
        b = 8'($urandom);
        if (i < cl - 1) b[7] = 1'b1;
        else if (i == cl - 1) b[7] = 1'b0;
        put_byte(b);
      end
    end
    mode = $urandom_range(9, 0);
    case (mode)
      5, 6: begin
        if (cfg_max_id < 8'd255) id = $urandom_range(255, int'(cfg_max_id) + 1);
        else if (prev > 1) id = $urandom_range(prev - 1, 1);
        else id = -1;
        if (id >= 0) put_byte(8'(id));
        repeat ($urandom_range(3, 0)) put_byte(8'($urandom));
      end
      7: begin
        put_byte(8'h00);
        repeat ($urandom_range(7, 5)) put_byte(8'h80 | 8'($urandom));
        repeat ($urandom_range(2, 0)) put_byte(8'($urandom));
      end
      8: begin
        put_byte(8'h00);
        repeat (4) put_byte(8'hff);
        put_byte(8'($urandom_range(127, 0)));
        repeat ($urandom_range(4, 1)) put_byte(8'($urandom));
      end
      9: begin
        cut = $urandom_range(stream_buf.size() - 1, 1);
        while (stream_buf.size() > cut) void'(stream_buf.pop_back());
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : verdict_monitor
    verdict_rec_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t unexpected transfer: expected none, got verdict %0d length %h",
                 $time, out_if.verdict, out_if.match_length);
        err_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 32'(want.verdict), 32'(out_if.verdict));
        check_field("match_length", want.match_len, out_if.match_length);
        check_field("module_version", want.mod_ver, out_if.module_version);
        check_field("section_total", want.sec_total, out_if.section_total);
        check_field("type_total", want.type_cnt, out_if.type_total);
        check_field("import_total", want.import_cnt, out_if.import_total);
        check_field("function_total", want.func_cnt, out_if.function_total);
        check_field("export_total", want.export_cnt, out_if.export_total);
      end
    end
  end

  initial begin : result_sink
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(sink_burst);
      // one long hold so the block backs up into its input
      if (results_taken == 30) gap = 300;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      results_taken++;
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  row_bytes[$];
    logic [7:0]  nib;
    logic [7:0]  acc;
    int          nnib;
    int          target;
    logic [7:0]  phase_id[PHASES];
    logic [31:0] phase_ver[PHASES];

    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    cfg_max_id  = wmsc_pkg::RESET_MAX_SECTION_ID;
    cfg_max_ver = wmsc_pkg::RESET_MAX_VERSION;
    clear_stream();

    stim_table = '{
      '{"00 61 73 6e 00", 1'b1, NO_MATCH_REC},
      '{"ff", 1'b1, NO_MATCH_REC},
      '{"00 61 73 6d 01 00", 1'b1, NO_MATCH_REC},
      '{HDR, 1'b1, NO_MATCH_REC},
      '{"00 61 73 6d 00 00 00 00 01", 1'b1, NO_MATCH_REC},
      '{"00 61 73 6d 02 00 00 00", 1'b1, NO_MATCH_REC},
      '{{HDR, " 0d"}, 1'b1, NO_MATCH_REC},
      '{{HDR, " 01 04 01 60 00 00 03 02 01 00 07 05 01 01 61 00 00"}, 1'b0, '0},
      '{{HDR, " 00 00 0d 55"}, 1'b0, '0},
      '{{HDR, " 03 01 00 01 01 00"}, 1'b0, '0},
      '{{HDR, " 01"}, 1'b1, '{wmsc_pkg::VERDICT_PART_HEADER, 32'd9, 32'd1, 32'd0, 32'd0,
                            32'd0, 32'd0, 32'd0}},
      '{{HDR, " 01 80"}, 1'b0, '0},
      '{{HDR, " 00 80 80 80 80 80 80 80"}, 1'b1,
        '{wmsc_pkg::VERDICT_PART_HEADER, 32'd16, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
      '{{HDR, " 02 05 83 01"}, 1'b0, '0},
      '{{HDR, " 00 ff ff ff ff 7f 11"}, 1'b0, '0},
      '{{HDR, " 00 80 80 80 80 0f 22"}, 1'b0, '0},
      '{{HDR, " 01 01 80 02 02 81 01"}, 1'b0, '0},
      '{{HDR, " 03 06 ff ff ff ff 10 00 07 06 80 80 80 80 80 00"}, 1'b0, '0},
      '{{HDR, " 0c 00"}, 1'b1, '{wmsc_pkg::VERDICT_MATCHED, 32'd10, 32'd1, 32'd1, 32'd0,
                                32'd0, 32'd0, 32'd0}},
      '{{HDR, " 07 01 00 00 00 07 01 05"}, 1'b0, '0}
    };

    phase_id  = '{8'd0, 8'd255, 8'd7, 8'($urandom), wmsc_pkg::RESET_MAX_SECTION_ID};
    phase_ver = '{32'd1, wmsc_pkg::SAT32, 32'd3, $urandom | 32'd1,
                  wmsc_pkg::RESET_MAX_VERSION};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[r]) begin
      row_bytes.delete();
      nnib = 0;
      acc  = '0;
      for (int i = 0; i < stim_table[r].hexbytes.len(); i++) begin
        nib = stim_table[r].hexbytes.getc(i);
        if (nib == " ") continue;
        nib = (nib >= "a") ? nib - "a" + 8'd10 : nib - "0";
        acc = {acc[3:0], nib[3:0]};
        nnib++;
        if (nnib % 2 == 0) row_bytes.insert(row_bytes.size(), acc);
      end
      send_stream(row_bytes, stim_table[r].typed, stim_table[r].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(wmsc_pkg::REG_MAX_SECTION_ID, 32'(phase_id[p]));
      write_reg(wmsc_pkg::REG_MAX_VERSION, phase_ver[p]);
      target = accepted_bytes + BYTES_PER_PHASE;
      while (accepted_bytes < target) begin
        build_random_stream();
        send_stream(stream_buf, 1'b0, '0);
      end
    end

    drain();
    if (pending_verdicts.size() != 0) begin
      $display("%0t %0d verdicts expected but never transferred", $time, pending_verdicts.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
